FILE: rtl/core/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Round constants, initial hash values, state codes and a rotate-right helper.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int BLK_WORDS = 16;
    localparam int HASH_WORDS = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    localparam logic [31:0] HASH_INIT [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: rtl/core/sha_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read a cycle, registered read data.
// ----------------------------------------------------------------------------
module sha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: rtl/core/sha256_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher core
// Byte-serial SHA-256 with block words held in a 16-entry word memory.
// ----------------------------------------------------------------------------
// Takes one message byte per request and builds 32-bit words big-endian in a
// shift register; each full word is written to a 16 x 32 block memory. On the
// 64th byte of a block, or on an end-of-message request, the core stops taking
// requests (o_stall high) and compresses: at the end of a message, padding
// words are first written one per cycle; then 64 rounds run at one round per
// cycle after a memory prefetch in ST_LOAD, and the hash is updated in
// ST_UPDATE. A second padding block is compressed when the length does not fit
// the last block, including a message whose last byte fills a block, before
// the digest is sent out; i_stall holds the output.
// Rounds 0..15 take their word from the memory; the whole schedule is then
// kept in a 16-deep word shift line, so rounds 16..63 read w[r-16], w[r-15],
// w[r-7] and w[r-2] from fixed taps. The eight digest words go out as h0..h7,
// the eighth marked by o_digest_last, after which the hash returns to the
// initial values. Requests without byte and end are taken and dropped.
module sha256_stream_hasher_core
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_digest_last
);
    t_state r_state, n_state;

    logic [31:0] r_hash [HASH_WORDS];
    logic [31:0] r_wv   [HASH_WORDS];
    // full schedule kept as a 16-word shift line: r_w[0] is w[r-1]
    logic [31:0] r_w    [BLK_WORDS];
    logic [31:0] r_acc;
    logic [5:0]  r_fill;
    logic [63:0] r_len;
    logic [6:0]  r_rnd;
    logic [3:0]  r_pw;
    logic        r_final;
    logic        r_second;
    logic        r_pad_pend;
    logic [2:0]  r_out;

    logic        accept;
    logic        mem_we;
    logic [3:0]  mem_addr;
    logic [31:0] mem_wdata, mem_rdata;
    logic [31:0] acc_next;
    logic [31:0] w_cur, w15, w2, x0, x1, s0, s1, ch, mj, t1, t2;

    sha_ram #(.WIDTH(32), .DEPTH(BLK_WORDS)) u_blk (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign o_stall = (r_state != ST_IDLE);
    assign accept  = i_valid && !o_stall;
    assign acc_next = {r_acc[23:0], i_data_byte};

    // round datapath
    assign w15 = r_w[14];
    assign w2  = r_w[1];
    assign x0  = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
    assign x1  = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
    assign w_cur = (r_rnd < 7'd16) ? mem_rdata : (r_w[15] + x0 + r_w[6] + x1);
    assign s1 = ror32(r_wv[4], 6) ^ ror32(r_wv[4], 11) ^ ror32(r_wv[4], 25);
    assign ch = (r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]);
    assign t1 = r_wv[7] + s1 + ch + ROUND_K[r_rnd[5:0]] + w_cur;
    assign s0 = ror32(r_wv[0], 2) ^ ror32(r_wv[0], 13) ^ ror32(r_wv[0], 22);
    assign mj = (r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]);
    assign t2 = s0 + mj;

    // memory port
    always_comb begin
        mem_we = 1'b0;
        mem_addr = r_fill[5:2];
        mem_wdata = acc_next;
        case (r_state)
            ST_IDLE: begin
                mem_we = accept && i_has_byte && (r_fill[1:0] == 2'd3);
            end
            ST_PAD: begin
                mem_we = 1'b1;
                mem_addr = r_pw;
                // first pad word of the tail carries the pad byte
                if (r_pad_pend) begin
                    mem_wdata = r_acc;
                end else if (r_second && r_pw == 4'd14) begin
                    mem_wdata = r_len[63:32];
                end else if (r_second && r_pw == 4'd15) begin
                    mem_wdata = r_len[31:0];
                end else begin
                    mem_wdata = 32'd0;
                end
            end
            ST_LOAD: begin
                mem_addr = 4'd0;
            end
            ST_ROUND: begin
                mem_addr = r_rnd[3:0] + 4'd1;
            end
            default: begin
                mem_addr = r_fill[5:2];
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    // a byte that fills the block is compressed before any padding
                    if (i_has_byte && r_fill == 6'd63) begin
                        n_state = ST_LOAD;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD:   if (r_pw == 4'd15) n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_ROUND;
            ST_ROUND: if (r_rnd == 7'd63) n_state = ST_UPDATE;
            ST_UPDATE: begin
                if (!r_final) n_state = ST_IDLE;
                else if (r_second) n_state = ST_EMIT;
                else n_state = ST_PAD;
            end
            ST_EMIT: if (!i_stall && r_out == 3'd7) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_valid = (r_state == ST_EMIT);
        o_digest_word = r_hash[r_out];
        o_word_index = r_out;
        o_digest_last = (r_out == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill <= '0;
            r_len <= '0;
            r_final <= 1'b0;
            r_second <= 1'b0;
            r_pad_pend <= 1'b0;
            r_out <= '0;
            r_rnd <= '0;
            r_pw <= '0;
            for (int i = 0; i < HASH_WORDS; i++) r_hash[i] <= HASH_INIT[i];
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        logic [31:0] a;
                        logic [5:0]  f;
                        logic [63:0] l;
                        a = r_acc;
                        f = r_fill;
                        l = r_len;
                        if (i_has_byte) begin
                            a = acc_next;
                            f = r_fill + 6'd1;
                            l = r_len + 64'd8;
                        end
                        r_len <= l;
                        if (i_end_of_message) begin
                            // pad byte completes the current word
                            case (f[1:0])
                                2'd0: a = {PAD_BYTE, 24'd0};
                                2'd1: a = {a[7:0], PAD_BYTE, 16'd0};
                                2'd2: a = {a[15:0], PAD_BYTE, 8'd0};
                                default: a = {a[23:0], PAD_BYTE};
                            endcase
                            r_acc <= a;
                            r_final <= 1'b1;
                            r_pad_pend <= 1'b1;
                            // length fits this block when fill after pad <= 56;
                            // a byte filling the block pushes the pad to a new one
                            if (i_has_byte && r_fill == 6'd63) begin
                                r_second <= 1'b0;
                            end else begin
                                r_second <= (f < 6'd56);
                            end
                            r_pw <= f[5:2];
                            r_fill <= f;
                        end else begin
                            r_acc <= a;
                            r_fill <= f;
                        end
                        r_rnd <= '0;
                    end
                end
                ST_PAD: begin
                    r_pw <= r_pw + 4'd1;
                    r_pad_pend <= 1'b0;
                    if (r_pw == 4'd15) begin
                        r_rnd <= '0;
                    end
                end
                ST_LOAD: begin
                    for (int i = 0; i < HASH_WORDS; i++) r_wv[i] <= r_hash[i];
                end
                ST_ROUND: begin
                    for (int i = 7; i > 0; i--) begin
                        if (i == 4) r_wv[i] <= r_wv[3] + t1;
                        else r_wv[i] <= r_wv[i-1];
                    end
                    r_wv[0] <= t1 + t2;
                    for (int i = 15; i > 0; i--) r_w[i] <= r_w[i-1];
                    r_w[0] <= w_cur;
                    r_rnd <= r_rnd + 7'd1;
                end
                ST_UPDATE: begin
                    for (int i = 0; i < HASH_WORDS; i++) r_hash[i] <= r_hash[i] + r_wv[i];
                    r_fill <= '0;
                    if (r_final) begin
                        r_second <= 1'b1;
                        r_pw <= '0;
                    end
                end
                ST_EMIT: begin
                    if (!i_stall) begin
                        r_out <= r_out + 3'd1;
                        if (r_out == 3'd7) begin
                            for (int i = 0; i < HASH_WORDS; i++) r_hash[i] <= HASH_INIT[i];
                            r_len <= '0;
                            r_final <= 1'b0;
                            r_second <= 1'b0;
                            r_fill <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
